### rtl/core/assert_macros.svh
// Assertion macros shared by the console engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in a cycle, consequent in the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/tcce_pkg.sv
// Shared types, codes and constants of the text console cursor engine.
package tcce_pkg;

    localparam int SCREEN_WIDTH_DEF  = 80;
    localparam int SCREEN_HEIGHT_DEF = 25;

    localparam logic [7:0]  CH_NEWLINE    = 8'h0A;
    localparam logic [7:0]  CH_RETURN     = 8'h0D;
    localparam logic [7:0]  CH_TAB        = 8'h09;
    localparam logic [7:0]  CH_BACKSPACE  = 8'h08;
    localparam logic [7:0]  CH_SPACE      = 8'h20;
    localparam logic [7:0]  CH_PRINT_LAST = 8'h7F;
    localparam logic [7:0]  TAB_MASK      = ~8'd7;
    localparam logic [15:0] RESET_CELL    = 16'h0720;

    // configuration register indexes
    localparam logic CFG_FOREGROUND = 1'b0;
    localparam logic CFG_BACKGROUND = 1'b1;

    typedef enum logic [1:0] {
        OP_PUT        = 2'd0,
        OP_SET_CURSOR = 2'd1,
        OP_CLEAR      = 2'd2,
        OP_READ       = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        K_IGNORE,
        K_PRINT,
        K_NEWLINE,
        K_RETURN,
        K_TAB,
        K_BACKSPACE,
        K_SET,
        K_CLEAR,
        K_READ
    } kind_t;

    typedef enum logic [3:0] {
        CUR_NONE,
        CUR_ADVANCE,
        CUR_NEWLINE,
        CUR_RETURN,
        CUR_TAB,
        CUR_BACK,
        CUR_SET,
        CUR_HOME,
        CUR_LAST_ROW
    } cur_op_t;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_WR_CHAR,
        MEM_WR_BLANK_CUR,
        MEM_RD_INDEX,
        MEM_RD_BELOW,
        MEM_WR_COPY,
        MEM_WR_BLANK_PTR,
        MEM_WR_RESET
    } mem_op_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_INC
    } ptr_op_t;

    // datapath half of a control word
    typedef struct packed {
        logic    accept;
        logic    emit;
        cur_op_t cur;
        mem_op_t mem;
        ptr_op_t ptr;
    } dp_ctrl_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic  in_fire;
        logic  out_full;
        logic  sweep_more;
        logic  copy_more;
        logic  no_scroll;
        kind_t kind;
    } seq_status_t;

    function automatic kind_t classify(opcode_t op, logic [7:0] ch);
        kind_t k;
        k = K_IGNORE;
        case (op)
            OP_PUT:
            begin
                if (ch == CH_NEWLINE)
                    k = K_NEWLINE;
                else if (ch == CH_RETURN)
                    k = K_RETURN;
                else if (ch == CH_TAB)
                    k = K_TAB;
                else if (ch == CH_BACKSPACE)
                    k = K_BACKSPACE;
                else if (ch >= CH_SPACE && ch <= CH_PRINT_LAST)
                    k = K_PRINT;
                else
                    k = K_IGNORE;
            end
            OP_SET_CURSOR: k = K_SET;
            OP_CLEAR:      k = K_CLEAR;
            OP_READ:       k = K_READ;
            default:       k = K_IGNORE;
        endcase
        return k;
    endfunction

endpackage

### rtl/core/tcce_sequencer.sv
// Microprogram sequencer: step counter, control ROM and branch logic.
module tcce_sequencer
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tcce_pkg::seq_status_t status,
    output tcce_pkg::dp_ctrl_t    ctrl
);

    typedef enum logic [4:0] {
        S_RST0,
        S_RST1,
        S_IDLE,
        S_DISPATCH,
        S_PRINT,
        S_NEWLINE,
        S_RETURN,
        S_TAB,
        S_BACK,
        S_BACK_WR,
        S_SET,
        S_CLEAR0,
        S_CLEAR1,
        S_EMIT,
        S_READ,
        S_CHECK,
        S_SCROLL0,
        S_SCROLL1,
        S_SCROLL2,
        S_SCROLL3,
        S_DONE
    } step_t;

    typedef enum logic [1:0] {
        H_NONE,
        H_NO_INPUT,
        H_OUT_FULL
    } hold_t;

    typedef enum logic [2:0] {
        J_NEVER,
        J_ALWAYS,
        J_DISPATCH,
        J_SWEEP_MORE,
        J_COPY_MORE,
        J_NO_SCROLL
    } jump_t;

    typedef struct packed {
        tcce_pkg::dp_ctrl_t dp;
        hold_t              hold;
        jump_t              jump;
        step_t              target;
    } rom_word_t;

    function automatic rom_word_t rom(step_t s);
        rom_word_t w;
        w = '0;
        case (s)
            S_RST0:
                w.dp.ptr = tcce_pkg::PTR_ZERO;
            S_RST1:
            begin
                w.dp.mem = tcce_pkg::MEM_WR_RESET;
                w.dp.ptr = tcce_pkg::PTR_INC;
                w.jump   = J_SWEEP_MORE;
                w.target = S_RST1;
            end
            S_IDLE:
            begin
                w.dp.accept = 1'b1;
                w.hold      = H_NO_INPUT;
            end
            S_DISPATCH:
                w.jump = J_DISPATCH;
            S_PRINT:
            begin
                w.dp.mem = tcce_pkg::MEM_WR_CHAR;
                w.dp.cur = tcce_pkg::CUR_ADVANCE;
                w.jump   = J_ALWAYS;
                w.target = S_CHECK;
            end
            S_NEWLINE:
            begin
                w.dp.cur = tcce_pkg::CUR_NEWLINE;
                w.jump   = J_ALWAYS;
                w.target = S_CHECK;
            end
            S_RETURN:
            begin
                w.dp.cur = tcce_pkg::CUR_RETURN;
                w.jump   = J_ALWAYS;
                w.target = S_EMIT;
            end
            S_TAB:
            begin
                w.dp.cur = tcce_pkg::CUR_TAB;
                w.jump   = J_ALWAYS;
                w.target = S_CHECK;
            end
            S_BACK:
                w.dp.cur = tcce_pkg::CUR_BACK;
            S_BACK_WR:
            begin
                w.dp.mem = tcce_pkg::MEM_WR_BLANK_CUR;
                w.jump   = J_ALWAYS;
                w.target = S_EMIT;
            end
            S_SET:
            begin
                w.dp.cur = tcce_pkg::CUR_SET;
                w.jump   = J_ALWAYS;
                w.target = S_EMIT;
            end
            S_CLEAR0:
            begin
                w.dp.ptr = tcce_pkg::PTR_ZERO;
                w.dp.cur = tcce_pkg::CUR_HOME;
            end
            S_CLEAR1:
            begin
                w.dp.mem = tcce_pkg::MEM_WR_BLANK_PTR;
                w.dp.ptr = tcce_pkg::PTR_INC;
                w.jump   = J_SWEEP_MORE;
                w.target = S_CLEAR1;
            end
            S_EMIT:
            begin
                w.dp.emit = 1'b1;
                w.hold    = H_OUT_FULL;
                w.jump    = J_ALWAYS;
                w.target  = S_IDLE;
            end
            S_READ:
            begin
                w.dp.mem = tcce_pkg::MEM_RD_INDEX;
                w.jump   = J_ALWAYS;
                w.target = S_EMIT;
            end
            S_CHECK:
            begin
                w.jump   = J_NO_SCROLL;
                w.target = S_EMIT;
            end
            S_SCROLL0:
            begin
                w.dp.ptr = tcce_pkg::PTR_ZERO;
                w.dp.cur = tcce_pkg::CUR_LAST_ROW;
            end
            S_SCROLL1:
                w.dp.mem = tcce_pkg::MEM_RD_BELOW;
            S_SCROLL2:
            begin
                w.dp.mem = tcce_pkg::MEM_WR_COPY;
                w.dp.ptr = tcce_pkg::PTR_INC;
                w.jump   = J_COPY_MORE;
                w.target = S_SCROLL1;
            end
            S_SCROLL3:
            begin
                w.dp.mem = tcce_pkg::MEM_WR_BLANK_PTR;
                w.dp.ptr = tcce_pkg::PTR_INC;
                w.jump   = J_SWEEP_MORE;
                w.target = S_SCROLL3;
            end
            S_DONE:
            begin
                w.jump   = J_ALWAYS;
                w.target = S_EMIT;
            end
            default:
            begin
                w.jump   = J_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic step_t entry(tcce_pkg::kind_t k);
        step_t s;
        s = S_EMIT;
        case (k)
            tcce_pkg::K_PRINT:     s = S_PRINT;
            tcce_pkg::K_NEWLINE:   s = S_NEWLINE;
            tcce_pkg::K_RETURN:    s = S_RETURN;
            tcce_pkg::K_TAB:       s = S_TAB;
            tcce_pkg::K_BACKSPACE: s = S_BACK;
            tcce_pkg::K_SET:       s = S_SET;
            tcce_pkg::K_CLEAR:     s = S_CLEAR0;
            tcce_pkg::K_READ:      s = S_READ;
            default:               s = S_EMIT;
        endcase
        return s;
    endfunction

    step_t     upc_reg;
    step_t     upc_next;
    rom_word_t word;
    logic      hold_now;
    logic      jump_now;

    assign word = rom(upc_reg);
    assign ctrl = word.dp;

    always_comb
    begin
        case (word.hold)
            H_NONE:     hold_now = 1'b0;
            H_NO_INPUT: hold_now = !status.in_fire;
            H_OUT_FULL: hold_now = status.out_full;
            default:    hold_now = 1'b0;
        endcase
        case (word.jump)
            J_NEVER:      jump_now = 1'b0;
            J_ALWAYS:     jump_now = 1'b1;
            J_DISPATCH:   jump_now = 1'b1;
            J_SWEEP_MORE: jump_now = status.sweep_more;
            J_COPY_MORE:  jump_now = status.copy_more;
            J_NO_SCROLL:  jump_now = status.no_scroll;
            default:      jump_now = 1'b0;
        endcase
        if (hold_now)
            upc_next = upc_reg;
        else if (jump_now && word.jump == J_DISPATCH)
            upc_next = entry(status.kind);
        else if (jump_now)
            upc_next = word.target;
        else
            upc_next = step_t'(upc_reg + 5'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= S_RST0;
        else
            upc_reg <= upc_next;
    end

endmodule

### rtl/core/text_console_cursor_engine_unit.sv
// Text console cursor engine: screen store, cursor datapath and stream ports.
//
//  channel   dir  handshake                       content
//  s_axis    in   s_axis_tvalid / s_axis_tready   command beat, opcode in tuser
//  m_axis    out  m_axis_tvalid / m_axis_tready   cursor and read data, one per command
//  cfg       in   cfg_wr_en                       foreground / background color
//
// A scroll copies each row up one line, with one read and one write per cell, and then
// blanks the last row. Clear screen blanks every cell and homes the cursor.
// After reset a pass fills the store with blanks before the first command is taken;
// color writes are taken meanwhile.
// A finished result waits in the output register while the next command is taken.
`include "assert_macros.svh"

module text_console_cursor_engine_unit
#(
    parameter int SCREEN_WIDTH  = tcce_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tcce_pkg::SCREEN_HEIGHT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // char_code, target_column, target_row, cell_index
    input  logic [1:0]  s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // cursor_column, cursor_row, cursor_address, read_data
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [3:0]  cfg_wdata
);

    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int AW1   = AW + 1;

    tcce_pkg::dp_ctrl_t    ctrl;
    tcce_pkg::seq_status_t status;

    // command latched at accept
    tcce_pkg::opcode_t cmd_op_reg;
    logic [7:0]        cmd_ch_reg;
    logic [6:0]        cmd_col_reg;
    logic [4:0]        cmd_row_reg;
    logic [10:0]       cmd_ci_reg;

    logic [6:0]    col_reg, col_next;
    logic [5:0]    row_reg, row_next;   // one spare bit: row may reach H before scroll
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [3:0]    fg_reg, bg_reg;
    logic          out_valid_reg, out_valid_next;
    logic [39:0]   out_data_reg, out_data_next;

    logic [15:0]   mem [CELLS];
    logic [15:0]   mem_q;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0]   mem_wdata;

    logic          in_fire, out_full, emit_now;
    logic [7:0]    attr;
    logic [AW-1:0] cur_addr, ptr_below;
    logic [7:0]    col_adv, col_tab;
    logic          ci_in_range;
    logic [15:0]   read_val;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_full = out_valid_reg && !m_axis_tready;
    assign emit_now = ctrl.emit && !out_full;
    assign attr     = {bg_reg, fg_reg};

    assign cur_addr  = AW'(AW'(row_reg) * AW'(SCREEN_WIDTH) + AW'(col_reg));
    assign ptr_below = AW'(ptr_reg + AW'(SCREEN_WIDTH));
    assign col_adv   = {1'b0, col_reg} + 8'd1;
    assign col_tab   = ({1'b0, col_reg} + 8'd8) & tcce_pkg::TAB_MASK;

    assign ci_in_range = 13'(cmd_ci_reg) < 13'(CELLS);
    assign read_val    = (cmd_op_reg == tcce_pkg::OP_READ && ci_in_range) ? mem_q : 16'd0;

    assign status.in_fire    = in_fire;
    assign status.out_full   = out_full;
    assign status.sweep_more = ptr_reg != AW'(CELLS - 1);
    assign status.copy_more  = ptr_reg != AW'(CELLS - SCREEN_WIDTH - 1);
    assign status.no_scroll  = row_reg < 6'(SCREEN_HEIGHT);
    assign status.kind       = tcce_pkg::classify(cmd_op_reg, cmd_ch_reg);

    tcce_sequencer u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    assign s_axis_tready = ctrl.accept;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // cursor moves
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        case (ctrl.cur)
            tcce_pkg::CUR_NONE: ;
            tcce_pkg::CUR_ADVANCE:
            begin
                if (col_adv >= 8'(SCREEN_WIDTH))
                begin
                    col_next = 7'd0;
                    row_next = row_reg + 6'd1;
                end
                else
                    col_next = col_adv[6:0];
            end
            tcce_pkg::CUR_NEWLINE:
            begin
                col_next = 7'd0;
                row_next = row_reg + 6'd1;
            end
            tcce_pkg::CUR_RETURN:
                col_next = 7'd0;
            tcce_pkg::CUR_TAB:
            begin
                if (col_tab >= 8'(SCREEN_WIDTH))
                begin
                    col_next = 7'd0;
                    row_next = row_reg + 6'd1;
                end
                else
                    col_next = col_tab[6:0];
            end
            tcce_pkg::CUR_BACK:
            begin
                // top left corner stays put
                if (col_reg != 7'd0)
                    col_next = col_reg - 7'd1;
                else if (row_reg != 6'd0)
                begin
                    row_next = row_reg - 6'd1;
                    col_next = 7'(SCREEN_WIDTH - 1);
                end
            end
            tcce_pkg::CUR_SET:
            begin
                col_next = (cmd_col_reg > 7'(SCREEN_WIDTH - 1)) ?
                           7'(SCREEN_WIDTH - 1) : cmd_col_reg;
                row_next = ({1'b0, cmd_row_reg} > 6'(SCREEN_HEIGHT - 1)) ?
                           6'(SCREEN_HEIGHT - 1) : {1'b0, cmd_row_reg};
            end
            tcce_pkg::CUR_HOME:
            begin
                col_next = 7'd0;
                row_next = 6'd0;
            end
            tcce_pkg::CUR_LAST_ROW:
            begin
                col_next = 7'd0;
                row_next = 6'(SCREEN_HEIGHT - 1);
            end
            default: ;
        endcase
    end

    // store port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = ptr_reg;
        mem_raddr = ptr_below;
        mem_wdata = tcce_pkg::RESET_CELL;
        case (ctrl.mem)
            tcce_pkg::MEM_NONE: ;
            tcce_pkg::MEM_WR_CHAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_addr;
                mem_wdata = {attr, cmd_ch_reg};
            end
            tcce_pkg::MEM_WR_BLANK_CUR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_addr;
                mem_wdata = {attr, tcce_pkg::CH_SPACE};
            end
            tcce_pkg::MEM_RD_INDEX:
            begin
                mem_re    = 1'b1;
                mem_raddr = AW'(cmd_ci_reg);
            end
            tcce_pkg::MEM_RD_BELOW:
                mem_re = 1'b1;
            tcce_pkg::MEM_WR_COPY:
            begin
                mem_we    = 1'b1;
                mem_wdata = mem_q;
            end
            tcce_pkg::MEM_WR_BLANK_PTR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {attr, tcce_pkg::CH_SPACE};
            end
            tcce_pkg::MEM_WR_RESET:
                mem_we = 1'b1;
            default: ;
        endcase
    end

    always_comb
    begin
        case (ctrl.ptr)
            tcce_pkg::PTR_HOLD: ptr_next = ptr_reg;
            tcce_pkg::PTR_ZERO: ptr_next = '0;
            tcce_pkg::PTR_INC:  ptr_next = AW'(ptr_reg + AW'(1));
            default:            ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;
        if (emit_now)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {1'b0, read_val, 11'(cur_addr), row_reg[4:0], col_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_q <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        out_data_reg <= out_data_next;
        if (in_fire)
        begin
            cmd_op_reg  <= tcce_pkg::opcode_t'(s_axis_tuser);
            cmd_ch_reg  <= s_axis_tdata[7:0];
            cmd_col_reg <= s_axis_tdata[14:8];
            cmd_row_reg <= s_axis_tdata[19:15];
            cmd_ci_reg  <= s_axis_tdata[30:20];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= 7'd0;
            row_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
            fg_reg        <= 4'd7;
            bg_reg        <= 4'd0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    tcce_pkg::CFG_FOREGROUND: fg_reg <= cfg_wdata;
                    tcce_pkg::CFG_BACKGROUND: bg_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    `ASSERT_CLK(a_cursor_on_screen, s_axis_tready |-> ({1'b0, col_reg} < 8'(SCREEN_WIDTH) && row_reg < 6'(SCREEN_HEIGHT)), "cursor off screen while idle")
    `ASSERT_CLK(a_write_in_store, mem_we |-> ({1'b0, mem_waddr} < AW1'(CELLS)), "store write beyond last cell")
    `ASSERT_CLK(a_scroll_only_on_overflow, (ctrl.cur == tcce_pkg::CUR_LAST_ROW) |-> (row_reg == 6'(SCREEN_HEIGHT)), "scroll without row overflow")
    `ASSERT_NEXT(a_emit_lands, emit_now, m_axis_tvalid, "emitted result not presented")

endmodule

### tb/sv/tb_text_console_cursor_engine_unit.sv
// Self-checking testbench for the console engine: stream driver, monitor, screen predictor.
module tb_text_console_cursor_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tcce_pkg::*;

    localparam int W            = SCREEN_WIDTH_DEF;
    localparam int H            = SCREEN_HEIGHT_DEF;
    localparam int CELLS        = W * H;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS  = 250;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 50_000_000;

    // command fields as packed into tdata, lowest field last in the list
    typedef struct packed {
        logic [10:0] cell_index;
        logic [4:0]  target_row;
        logic [6:0]  target_column;
        logic [7:0]  char_code;
    } cmd_fields_t;

    typedef struct packed {
        opcode_t     op;
        cmd_fields_t f;
    } console_cmd_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [10:0] cursor_address;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_column;
    } cursor_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // char_code, target_column, target_row, cell_index
    logic [1:0]  s_axis_tuser = '0;   // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // cursor_column, cursor_row, cursor_address, read_data
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [3:0]  cfg_wdata = '0;

    text_console_cursor_engine_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    logic [15:0]    screen_model [0:CELLS-1];
    int             cur_col;
    int             cur_row;
    logic [3:0]     fg_color;
    logic [3:0]     bg_color;

    console_cmd_t   command_q [$];
    cursor_report_t report_q [$];
    console_cmd_t   cmd_on_bus;

    int tx_idle_pct;
    int rx_idle_pct;
    int accepted;
    int err_count;
    int scroll_count;
    int print_count;
    int read_count;
    int clear_count;
    int color_settings;
    int hold_left;
    bit hold_done;

    function automatic cursor_report_t console_apply(input console_cmd_t c);
        cursor_report_t r;
        logic [15:0]    blank;
        logic [7:0]     ch;
        int             col;
        int             row;
        int             i;
        blank = {bg_color, fg_color, CH_SPACE};
        ch = c.f.char_code;
        col = cur_col;
        row = cur_row;
        r.read_data = '0;
        case (c.op)
            OP_PUT:
            begin
                if (ch == CH_NEWLINE)
                begin
                    col = 0;
                    row++;
                end
                else if (ch == CH_RETURN)
                    col = 0;
                else if (ch == CH_TAB)
                begin
                    col = (col + 8) & ~7;
                    if (col >= W)
                    begin
                        col = 0;
                        row++;
                    end
                end
                else if (ch == CH_BACKSPACE)
                begin
                    if (col > 0)
                        col--;
                    else if (row > 0)
                    begin
                        row--;
                        col = W - 1;
                    end
                    screen_model[row * W + col] = blank;
                end
                else if (ch >= CH_SPACE && ch <= CH_PRINT_LAST)
                begin
                    screen_model[row * W + col] = {bg_color, fg_color, ch};
                    print_count++;
                    col++;
                    if (col >= W)
                    begin
                        col = 0;
                        row++;
                    end
                end
                // ran off the bottom: shift up one line, blank the last one
                if (row >= H)
                begin
                    for (i = 0; i < CELLS - W; i++)
                        screen_model[i] = screen_model[i + W];
                    for (i = CELLS - W; i < CELLS; i++)
                        screen_model[i] = blank;
                    row = H - 1;
                    col = 0;
                    scroll_count++;
                end
            end
            OP_SET_CURSOR:
            begin
                col = (c.f.target_column > W - 1) ? W - 1 : int'(c.f.target_column);
                row = (c.f.target_row > H - 1) ? H - 1 : int'(c.f.target_row);
            end
            OP_CLEAR:
            begin
                for (i = 0; i < CELLS; i++)
                    screen_model[i] = blank;
                col = 0;
                row = 0;
                clear_count++;
            end
            default:
            begin
                if (c.f.cell_index < CELLS)
                    r.read_data = screen_model[c.f.cell_index];
                read_count++;
            end
        endcase
        cur_col = col;
        cur_row = row;
        r.cursor_column  = 7'(col);
        r.cursor_row     = 5'(row);
        r.cursor_address = 11'(row * W + col);
        return r;
    endfunction

    // command driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                report_q.push_back(console_apply(cmd_on_bus));
                accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (command_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    cmd_on_bus = command_q.pop_front();
                    s_axis_tdata <= {1'b0, cmd_on_bus.f};
                    s_axis_tuser <= cmd_on_bus.op;
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off so the block backs up into its input
    always @(posedge clk)
    begin
        if (!hold_done && accepted >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // result monitor
    always @(posedge clk)
    begin : rx_monitor
        cursor_report_t got;
        cursor_report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[38:0];
            if (report_q.size() == 0)
            begin
                $error("result beat with no command outstanding: %h", m_axis_tdata);
                err_count++;
            end
            else
            begin
                want = report_q.pop_front();
                if (got.cursor_column !== want.cursor_column)
                begin
                    $error("cursor_column expected %0d got %0d",
                           want.cursor_column, got.cursor_column);
                    err_count++;
                end
                if (got.cursor_row !== want.cursor_row)
                begin
                    $error("cursor_row expected %0d got %0d", want.cursor_row, got.cursor_row);
                    err_count++;
                end
                if (got.cursor_address !== want.cursor_address)
                begin
                    $error("cursor_address expected %0d got %0d",
                           want.cursor_address, got.cursor_address);
                    err_count++;
                end
                if (got.read_data !== want.read_data)
                begin
                    $error("read_data expected %h got %h", want.read_data, got.read_data);
                    err_count++;
                end
            end
        end
        m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic queue_cmd(input opcode_t op, input int ch, input int tc, input int tr,
                             input int ci);
        console_cmd_t c;
        c.op = op;
        c.f.char_code = 8'(ch);
        c.f.target_column = 7'(tc);
        c.f.target_row = 5'(tr);
        c.f.cell_index = 11'(ci);
        command_q.push_back(c);
    endtask

    task automatic write_color(input logic idx, input logic [3:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_FOREGROUND)
            fg_color = val;
        else
            bg_color = val;
    endtask

    task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
        write_color(CFG_FOREGROUND, fg);
        write_color(CFG_BACKGROUND, bg);
        color_settings++;
    endtask

    task automatic drain;
        while (command_q.size() != 0 || s_axis_tvalid || report_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic gen_random_phase(input int n);
        int made;
        int len;
        int roll;
        int k;
        int col;
        int row;
        int near_row;
        int ch;
        int ci;
        made = 0;
        while (made < n)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
            begin
                // noise: any opcode, every field full width
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++)
                    queue_cmd(opcode_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                              $urandom_range(0, 127), $urandom_range(0, 31),
                              $urandom_range(0, 2047));
                made += len;
            end
            else if (roll < 13)
            begin
                queue_cmd(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
                made++;
            end
            else
            begin
                near_row = -1;
                if ($urandom_range(0, 99) < 70)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 30)
                        col = $urandom_range(W - 8, W - 1);
                    else if (roll < 40)
                        col = $urandom_range(W, 127);
                    else
                        col = $urandom_range(0, W - 1);
                    roll = $urandom_range(0, 99);
                    if (roll < 15)
                        row = $urandom_range(H - 3, H - 1);
                    else if (roll < 20)
                        row = $urandom_range(H, 31);
                    else if (roll < 40)
                        row = $urandom_range(0, 1);
                    else
                        row = $urandom_range(0, H - 4);
                    queue_cmd(OP_SET_CURSOR, $urandom, col, row, $urandom);
                    made++;
                    near_row = (row > H - 1) ? H - 1 : row;
                end
                len = $urandom_range(1, 20);
                for (k = 0; k < len; k++)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 70)
                        ch = $urandom_range(CH_SPACE, CH_PRINT_LAST);
                    else if (roll < 78)
                        ch = CH_NEWLINE;
                    else if (roll < 83)
                        ch = CH_RETURN;
                    else if (roll < 90)
                        ch = CH_TAB;
                    else if (roll < 97)
                        ch = CH_BACKSPACE;
                    else if (roll < 99)
                        ch = $urandom_range(8'h80, 8'hFF);
                    else
                        ch = $urandom_range(8'h0E, 8'h1F);
                    queue_cmd(OP_PUT, ch, $urandom, $urandom, $urandom);
                end
                made += len;
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++)
                begin
                    roll = $urandom_range(0, 99);
                    if (near_row >= 0 && roll < 70)
                        ci = near_row * W + $urandom_range(0, W - 1);
                    else if (roll < 80)
                        ci = $urandom_range(CELLS, 2047);
                    else
                        ci = $urandom_range(0, CELLS - 1);
                    queue_cmd(OP_READ, $urandom, $urandom, $urandom, ci);
                end
                made += len;
            end
        end
    endtask

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("FAIL text_console_cursor_engine_unit");
        $finish;
    end

    initial
    begin : main_seq
        int i;
        int ph;
        for (i = 0; i < CELLS; i++)
            screen_model[i] = RESET_CELL;
        cur_col = 0;
        cur_row = 0;
        fg_color = 4'd7;
        bg_color = 4'd0;
        tx_idle_pct = 36;
        rx_idle_pct = 58;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        set_colors(4'hF, 4'h0);
        // directed: reset contents, byte classes, cursor corners, wrap and scroll
        queue_cmd(OP_READ, 0, 0, 0, 0);
        queue_cmd(OP_READ, 0, 0, 0, CELLS - 1);
        queue_cmd(OP_READ, 0, 0, 0, 2047);
        queue_cmd(OP_PUT, 8'h41, 0, 0, 0);
        queue_cmd(OP_PUT, CH_SPACE, 0, 0, 0);
        queue_cmd(OP_PUT, CH_PRINT_LAST, 0, 0, 0);
        queue_cmd(OP_PUT, 8'h00, 0, 0, 0);
        queue_cmd(OP_PUT, 8'hFF, 0, 0, 0);
        queue_cmd(OP_PUT, 8'h1F, 0, 0, 0);
        queue_cmd(OP_PUT, CH_TAB, 0, 0, 0);
        queue_cmd(OP_PUT, CH_RETURN, 0, 0, 0);
        queue_cmd(OP_PUT, CH_NEWLINE, 0, 0, 0);
        queue_cmd(OP_PUT, CH_BACKSPACE, 0, 0, 0);  // column 0: back to end of row above
        queue_cmd(OP_SET_CURSOR, 0, 0, 0, 0);
        queue_cmd(OP_PUT, CH_BACKSPACE, 0, 0, 0);  // top left: stays, blanks the cell
        queue_cmd(OP_SET_CURSOR, 0, 127, 31, 0);
        queue_cmd(OP_PUT, 8'h5A, 0, 0, 0);         // last cell, wraps and scrolls
        queue_cmd(OP_READ, 0, 0, 0, CELLS - W - 1);
        queue_cmd(OP_SET_CURSOR, 0, W - 4, 10, 0);
        queue_cmd(OP_PUT, CH_TAB, 0, 0, 0);
        queue_cmd(OP_SET_CURSOR, 0, 5, H - 1, 0);
        queue_cmd(OP_PUT, CH_NEWLINE, 0, 0, 0);
        queue_cmd(OP_READ, 0, 0, 0, CELLS);
        queue_cmd(OP_CLEAR, 0, 0, 0, 0);
        queue_cmd(OP_READ, 0, 0, 0, 0);
        drain();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph / 2)
                0:
                begin
                    tx_idle_pct = 36;
                    rx_idle_pct = 58;
                end
                1:
                begin
                    tx_idle_pct = 58;
                    rx_idle_pct = 36;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            case (ph)
                0: set_colors(4'h0, 4'hF);
                1: set_colors(4'hF, 4'hF);
                2: set_colors(4'h0, 4'h0);
                5: set_colors(4'h7, 4'h0);
                default: set_colors(4'($urandom), 4'($urandom));
            endcase
            gen_random_phase(PHASE_ITEMS);
            drain();
        end

        repeat (20) @(posedge clk);
        $display("covered %0d commands: %0d printed bytes, %0d scrolls, %0d clears,",
                 accepted, print_count, scroll_count, clear_count);
        $display("  %0d cell reads, %0d color settings, %0d mismatches",
                 read_count, color_settings, err_count);
        if (err_count == 0)
            $display("PASS text_console_cursor_engine_unit");
        else
            $display("FAIL text_console_cursor_engine_unit");
        $finish;
    end

endmodule
